// ----- src/sdq_pkg.sv -----
// sdq_pkg: shared types and constants for the sorted delay event queue
// no dependencies; imported by every module of the block
package sdq_pkg;

  localparam int unsigned TIME_W  = 32;  // delay and remaining time width
  localparam int unsigned EV_W    = 16;  // event payload width on the ports
  localparam int unsigned MAX_OUT = 16;  // most due events emitted per tick
  localparam int unsigned CNT_W   = 5;   // counts 0 .. MAX_OUT

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_SCHEDULED = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_DUE       = 3'd2,
    KIND_NONE_DUE  = 3'd3,
    KIND_CLEARED   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCH_FREE,
    ST_SCH_CMP,
    ST_SCH_LINK,
    ST_SCH_DONE,
    ST_TCK_SUB,
    ST_TCK_HEAD,
    ST_TCK_CHK,
    ST_TCK_DONE
  } state_e;

endpackage

// ----- src/sdq_time_unit.sv -----
// sdq_time_unit: shared subtractor for remaining times
// gives the saturated difference and a greater-than flag; uses sdq_pkg
module sdq_time_unit (
  input  logic [sdq_pkg::TIME_W-1:0] a_i,
  input  logic [sdq_pkg::TIME_W-1:0] b_i,
  output logic [sdq_pkg::TIME_W-1:0] diff_o,  // max(a - b, 0)
  output logic                       gt_o     // a > b
);
  import sdq_pkg::*;

  logic [TIME_W:0] diff;

  assign diff   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
  assign gt_o   = !diff[TIME_W] && (|diff[TIME_W-1:0]);

endmodule

// ----- src/sdq_node_mem.sv -----
// sdq_node_mem: slot storage for times, payloads and list links
// one registered read port shared by all three arrays; uses sdq_pkg
module sdq_node_mem #(
  parameter int unsigned NODES = 16,
  parameter int unsigned PW    = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        rd_en_i,
  input  logic [$clog2(NODES)-1:0]    rd_addr_i,
  output logic [sdq_pkg::TIME_W-1:0]  rd_time_o,
  output logic [PW-1:0]               rd_pay_o,
  output logic [$clog2(NODES+1)-1:0]  rd_link_o,
  input  logic                        time_we_i,
  input  logic [$clog2(NODES)-1:0]    time_addr_i,
  input  logic [sdq_pkg::TIME_W-1:0]  time_data_i,
  input  logic                        pay_we_i,
  input  logic [$clog2(NODES)-1:0]    pay_addr_i,
  input  logic [PW-1:0]               pay_data_i,
  input  logic                        link_we_i,
  input  logic [$clog2(NODES)-1:0]    link_addr_i,
  input  logic [$clog2(NODES+1)-1:0]  link_data_i
);
  import sdq_pkg::*;

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned AW = $clog2(NODES + 1);

  logic [TIME_W-1:0] time_mem [NODES];
  logic [PW-1:0]     pay_mem  [NODES];
  logic [AW-1:0]     link_mem [NODES];
  logic [NODES-1:0]  link_vld_q;

  logic [TIME_W-1:0] rd_time_q;
  logic [PW-1:0]     rd_pay_q;
  logic [AW-1:0]     rd_link_q;
  logic              rd_vld_q;
  logic [IW-1:0]     rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (time_we_i) begin
      time_mem[time_addr_i] <= time_data_i;
    end
    if (pay_we_i) begin
      pay_mem[pay_addr_i] <= pay_data_i;
    end
    if (link_we_i) begin
      link_mem[link_addr_i] <= link_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_time_q <= time_mem[rd_addr_i];
      rd_pay_q  <= pay_mem[rd_addr_i];
      rd_link_q <= link_mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // link valid bits: an unwritten link reads as the free chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (clear_i) begin
        link_vld_q <= '0;
      end else if (link_we_i) begin
        link_vld_q[link_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= link_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_time_o = rd_time_q;
  assign rd_pay_o  = rd_pay_q;
  assign rd_link_o = rd_vld_q ? rd_link_q : (AW'(rd_addr_q) + AW'(1));

endmodule

// ----- src/sorted_delay_event_queue_top.sv -----
// schedule: fetch the free slot, then walk the time list one entry per compare, and take a
// link step when the new entry lands behind an existing entry; a full queue reports KIND_FULL
// tick: sweep all live entries to lower their times, then unlink due events from the head
// one item at a time, input ready only while idle
// the single node memory read port and the shared subtractor serialise these steps
// reset: empty queue, free chain 0 .. NODES-1, no clearing pass needed
// sorted_delay_event_queue_top: sequencer, list registers and output stage
module sorted_delay_event_queue_top #(
  parameter int unsigned NODES      = 16,
  parameter int unsigned EVENT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [31:0] delay_ms, [47:32] event_in
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] event_out
  output logic [2:0]  m_axis_tuser_o,   // [2:0] kind
  output logic        m_axis_tlast_o    // last result of an input item
);
  import sdq_pkg::*;

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned AW = $clog2(NODES + 1);
  localparam int unsigned PW = (EVENT_BITS < EV_W) ? EVENT_BITS : EV_W;
  localparam logic [AW-1:0] NULL_LINK = AW'(NODES);

  // sequencer and list registers
  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [TIME_W-1:0] delay_q, delay_d;
  logic [PW-1:0]     ev_q, ev_d;
  logic [AW-1:0]     head_q, head_d;     // first slot of the time list
  logic [AW-1:0]     free_q, free_d;     // first free slot
  logic [IW-1:0]     slot_q, slot_d;     // slot taken by a schedule
  logic [IW-1:0]     cand_q, cand_d;     // slot under test in a walk
  logic [IW-1:0]     cur_q, cur_d;       // last slot passed in a walk
  logic              at_head_q, at_head_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;       // due events taken this tick
  logic              pend_q, pend_d;     // a due event held back to find last
  logic [PW-1:0]     pend_ev_q, pend_ev_d;

  // output stage
  logic              ov_q;
  kind_e             okind_q;
  logic [EV_W-1:0]   oev_q;
  logic              olast_q;
  logic              out_free;
  logic              emit;
  kind_e             emit_kind;
  logic [EV_W-1:0]   emit_ev;
  logic              emit_last;

  // node memory controls
  logic              mem_clear;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [TIME_W-1:0] rd_time;
  logic [PW-1:0]     rd_pay;
  logic [AW-1:0]     rd_link;
  logic              time_we, pay_we, link_we;
  logic [IW-1:0]     time_addr, link_addr;
  logic [TIME_W-1:0] time_data;
  logic [AW-1:0]     link_data;

  // shared subtractor: stored time against the latched delay
  logic [TIME_W-1:0] sat_diff;
  logic              time_gt;

  logic              in_xfer;
  logic              head_null, free_null, link_null, cnt_full, time_zero;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !ov_q || m_axis_tready_i;
  assign head_null       = (head_q == NULL_LINK);
  assign free_null       = (free_q == NULL_LINK);
  assign link_null       = (rd_link == NULL_LINK);
  assign cnt_full        = (cnt_q == CNT_W'(MAX_OUT));
  assign time_zero       = (rd_time == '0);

  sdq_node_mem #(
    .NODES (NODES),
    .PW    (PW)
  ) u_node_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (mem_clear),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_time_o   (rd_time),
    .rd_pay_o    (rd_pay),
    .rd_link_o   (rd_link),
    .time_we_i   (time_we),
    .time_addr_i (time_addr),
    .time_data_i (time_data),
    .pay_we_i    (pay_we),
    .pay_addr_i  (slot_q),
    .pay_data_i  (ev_q),
    .link_we_i   (link_we),
    .link_addr_i (link_addr),
    .link_data_i (link_data)
  );

  sdq_time_unit u_time_unit (
    .a_i    (rd_time),
    .b_i    (delay_q),
    .diff_o (sat_diff),
    .gt_o   (time_gt)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (cmd_q)
          CMD_SCHEDULE: begin
            if (!free_null) begin
              state_d = ST_SCH_FREE;
            end else if (out_free) begin
              state_d = ST_IDLE;
            end
          end
          CMD_TICK:  state_d = head_null ? ST_TCK_HEAD : ST_TCK_SUB;
          CMD_CLEAR: state_d = out_free ? ST_IDLE : ST_DISPATCH;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_SCH_FREE: state_d = head_null ? ST_SCH_DONE : ST_SCH_CMP;
      ST_SCH_CMP: begin
        if (time_gt) begin
          state_d = at_head_q ? ST_SCH_DONE : ST_SCH_LINK;
        end else if (link_null) begin
          state_d = ST_SCH_LINK;
        end
      end
      ST_SCH_LINK: state_d = ST_SCH_DONE;
      ST_SCH_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_TCK_SUB: begin
        if (link_null) begin
          state_d = ST_TCK_HEAD;
        end
      end
      ST_TCK_HEAD: state_d = (head_null || cnt_full) ? ST_TCK_DONE : ST_TCK_CHK;
      ST_TCK_CHK: begin
        if (!time_zero) begin
          state_d = ST_TCK_DONE;
        end else if (!pend_q || out_free) begin
          state_d = ST_TCK_HEAD;
        end
      end
      ST_TCK_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath, memory controls and result emission
  always_comb begin
    cmd_d     = cmd_q;
    delay_d   = delay_q;
    ev_d      = ev_q;
    head_d    = head_q;
    free_d    = free_q;
    slot_d    = slot_q;
    cand_d    = cand_q;
    cur_d     = cur_q;
    at_head_d = at_head_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    pend_ev_d = pend_ev_q;
    mem_clear = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = head_q[IW-1:0];
    time_we   = 1'b0;
    time_addr = slot_q;
    time_data = delay_q;
    pay_we    = 1'b0;
    link_we   = 1'b0;
    link_addr = slot_q;
    link_data = NULL_LINK;
    emit      = 1'b0;
    emit_kind = KIND_SCHEDULED;
    emit_ev   = '0;
    emit_last = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_d   = cmd_e'(s_axis_tuser_i);
          delay_d = s_axis_tdata_i[TIME_W-1:0];
          ev_d    = s_axis_tdata_i[TIME_W +: PW];
        end
      end
      ST_DISPATCH: begin
        case (cmd_q)
          CMD_SCHEDULE: begin
            if (!free_null) begin
              // fetch the free slot to learn the next free one
              slot_d  = free_q[IW-1:0];
              rd_en   = 1'b1;
              rd_addr = free_q[IW-1:0];
            end else if (out_free) begin
              emit      = 1'b1;
              emit_kind = KIND_FULL;
            end
          end
          CMD_TICK: begin
            cnt_d  = '0;
            pend_d = 1'b0;
            cand_d = head_q[IW-1:0];
            rd_en  = !head_null;
          end
          CMD_CLEAR: begin
            if (out_free) begin
              emit      = 1'b1;
              emit_kind = KIND_CLEARED;
              head_d    = NULL_LINK;
              free_d    = '0;
              mem_clear = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_SCH_FREE: begin
        free_d  = rd_link;
        time_we = 1'b1;
        pay_we  = 1'b1;
        if (head_null) begin
          // first entry of an empty list
          link_we = 1'b1;
          head_d  = AW'(slot_q);
        end else begin
          rd_en     = 1'b1;
          cand_d    = head_q[IW-1:0];
          at_head_d = 1'b1;
        end
      end
      ST_SCH_CMP: begin
        if (time_gt) begin
          // new entry goes in front of the candidate
          link_we   = 1'b1;
          link_data = AW'(cand_q);
          if (at_head_q) begin
            head_d = AW'(slot_q);
          end
        end else begin
          cur_d     = cand_q;
          at_head_d = 1'b0;
          if (link_null) begin
            link_we = 1'b1;  // new entry becomes the tail
          end else begin
            cand_d  = rd_link[IW-1:0];
            rd_en   = 1'b1;
            rd_addr = rd_link[IW-1:0];
          end
        end
      end
      ST_SCH_LINK: begin
        link_we   = 1'b1;
        link_addr = cur_q;
        link_data = AW'(slot_q);
      end
      ST_SCH_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_SCHEDULED;
        end
      end
      ST_TCK_SUB: begin
        // lower the time of the candidate, clamped at zero
        time_we   = 1'b1;
        time_addr = cand_q;
        time_data = sat_diff;
        if (!link_null) begin
          cand_d  = rd_link[IW-1:0];
          rd_en   = 1'b1;
          rd_addr = rd_link[IW-1:0];
        end
      end
      ST_TCK_HEAD: begin
        rd_en = !(head_null || cnt_full);
      end
      ST_TCK_CHK: begin
        if (time_zero && (!pend_q || out_free)) begin
          // unlink the head, return it to the free list
          emit      = pend_q;
          emit_kind = KIND_DUE;
          emit_ev   = EV_W'(pend_ev_q);
          emit_last = 1'b0;
          pend_d    = 1'b1;
          pend_ev_d = rd_pay;
          head_d    = rd_link;
          link_we   = 1'b1;
          link_addr = head_q[IW-1:0];
          link_data = free_q;
          free_d    = head_q;
          cnt_d     = cnt_q + CNT_W'(1);
        end
      end
      ST_TCK_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = pend_q ? KIND_DUE : KIND_NONE_DUE;
          emit_ev   = pend_q ? EV_W'(pend_ev_q) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= NULL_LINK;
      free_q  <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      free_q  <= free_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    delay_q   <= delay_d;
    ev_q      <= ev_d;
    slot_q    <= slot_d;
    cand_q    <= cand_d;
    cur_q     <= cur_d;
    at_head_q <= at_head_d;
    pend_ev_q <= pend_ev_d;
    if (emit) begin
      okind_q <= emit_kind;
      oev_q   <= emit_ev;
      olast_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = oev_q;
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;

endmodule
